[rtl/core/tlru_pkg.sv]
// Shared types and constants for the true LRU replacement block.
package tlru_pkg;

   localparam int SET_W  = 11;
   localparam int WAY_W  = 4;
   localparam int RANK_W = 4;

   localparam logic FUNC_QUERY  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef struct packed {
      logic             func;
      logic [SET_W-1:0] set_index;
      logic [WAY_W-1:0] way;
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

endpackage

[rtl/core/tlru_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module tlru_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tlru_rank.sv]
// Victim search and rank update over one set word.
module tlru_rank #(
   parameter int WAYS = 16
) (
   input  tlru_pkg::op_type                      op,
   input  logic [WAYS*tlru_pkg::RANK_W-1:0]      word_in,
   output logic [tlru_pkg::WAY_W-1:0]            victim,
   output logic                                  way_ok,
   output logic [WAYS*tlru_pkg::RANK_W-1:0]      word_out
);

   localparam int RW = tlru_pkg::RANK_W;

   logic [RW-1:0] rank_sel;

   always_comb begin
      rank_sel = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (tlru_pkg::WAY_W'(i) == op.way) begin
            rank_sel = word_in[i*RW +: RW];
         end
      end
   end

   always_comb begin
      victim = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (word_in[i*RW +: RW] == RW'(WAYS - 1)) begin
            victim = tlru_pkg::WAY_W'(i);
         end
      end
   end

   assign way_ok = ({1'b0, op.way} < (tlru_pkg::WAY_W + 1)'(WAYS));

   always_comb begin
      word_out = word_in;
      for (int i = 0; i < WAYS; i++) begin
         if (tlru_pkg::WAY_W'(i) == op.way) begin
            word_out[i*RW +: RW] = '0;
         end else if (word_in[i*RW +: RW] < rank_sel) begin
            word_out[i*RW +: RW] = word_in[i*RW +: RW] + RW'(1);
         end
      end
   end

endmodule

[rtl/core/true_lru_replacement.sv]
// True LRU replacement: per-set age ranks in RAM, victim query and rank update.
//
//   channel | ports                                      | direction
//   req     | req_valid req_stall req_func req_set_index req_way | in
//   rsp     | rsp_valid rsp_stall rsp_victim_way         | out
//
// A request reads its set word in the cycle it is accepted; the second stage
// then compares all ranks in parallel, writes the word back for a valid update and
// loads the response register once that register is free. One request per cycle unless
// stalled, with forwarding of a write to the same set. After reset the RAM is
// swept with the initial ranks, one set per cycle, while req_stall stays high.
// A stalled response holds the second stage, which then stalls requests.
module true_lru_replacement #(
   parameter int SETS = 2048,
   parameter int WAYS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [tlru_pkg::SET_W-1:0]    req_set_index,
   input  logic [tlru_pkg::WAY_W-1:0]    req_way,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlru_pkg::WAY_W-1:0]    rsp_victim_way
);

   localparam int IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WORD_W = WAYS * tlru_pkg::RANK_W;

   tlru_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;

   logic                s1_valid_ff, s1_valid_in;
   tlru_pkg::op_type    s1_op_ff;
   logic                s1_inrange_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0]   fwd_word_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [tlru_pkg::WAY_W-1:0] rsp_victim_way_ff;

   logic [WORD_W-1:0]   init_word;
   logic [WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]   cur_word;
   logic [WORD_W-1:0]   new_word;
   logic [WORD_W-1:0]   wr_word;
   logic [IDX_W-1:0]    wr_addr;
   logic [tlru_pkg::WAY_W-1:0] victim;
   logic                way_ok;
   logic                accept;
   logic                s1_go;
   logic                item_wr;
   logic                wr_en;
   logic                req_inrange;
   tlru_pkg::op_type    req_op;

   for (genvar g = 0; g < WAYS; g++) begin : g_init
      assign init_word[g*tlru_pkg::RANK_W +: tlru_pkg::RANK_W] = tlru_pkg::RANK_W'(g);
   end

   assign req_op.func      = req_func;
   assign req_op.set_index = req_set_index;
   assign req_op.way       = req_way;
   assign req_inrange      = (32'(req_set_index) < 32'(SETS));

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff == tlru_pkg::ST_CLEAR) || (s1_valid_ff && !s1_go);
   assign accept    = req_valid && !req_stall;

   assign cur_word = fwd_hit_ff ? fwd_word_ff : rd_word;

   tlru_rank #(.WAYS(WAYS)) u_rank (
      .op       (s1_op_ff),
      .word_in  (cur_word),
      .victim   (victim),
      .way_ok   (way_ok),
      .word_out (new_word)
   );

   assign item_wr = s1_go && s1_inrange_ff && (s1_op_ff.func == tlru_pkg::FUNC_UPDATE) && way_ok;
   assign wr_en   = (state_ff == tlru_pkg::ST_CLEAR) || item_wr;
   assign wr_addr = (state_ff == tlru_pkg::ST_CLEAR) ? clr_idx_ff : IDX_W'(s1_op_ff.set_index);
   assign wr_word = (state_ff == tlru_pkg::ST_CLEAR) ? init_word : new_word;

   tlru_ram #(.WIDTH(WORD_W), .DEPTH(SETS), .AW(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (IDX_W'(req_set_index)),
      .rd_data (rd_word)
   );

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         tlru_pkg::ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(SETS - 1)) begin
               state_in = tlru_pkg::ST_RUN;
            end
         end
         tlru_pkg::ST_RUN: begin
            state_in = tlru_pkg::ST_RUN;
         end
         default: begin
            state_in = tlru_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      fwd_hit_in = fwd_hit_ff;
      if (accept) begin
         fwd_hit_in = item_wr && (req_set_index == s1_op_ff.set_index);
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlru_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_op;
         s1_inrange_ff <= req_inrange;
         fwd_word_ff   <= new_word;
      end
      if (s1_go) begin
         rsp_victim_way_ff <= (s1_inrange_ff && (s1_op_ff.func == tlru_pkg::FUNC_QUERY))
                              ? victim : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_victim_way_ff;

`ifndef NO_ASSERTIONS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlru_pkg::ST_CLEAR) |-> !accept)
      else $error("request accepted during RAM clear");

   a_update_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_op_ff.func == tlru_pkg::FUNC_UPDATE)) |=> (rsp_valid && rsp_victim_way == '0))
      else $error("update response not zero");

   a_touched_rank0: assert property (@(posedge clock) disable iff (reset)
      item_wr |-> (wr_word[s1_op_ff.way*tlru_pkg::RANK_W +: tlru_pkg::RANK_W] == '0))
      else $error("touched way not made most recent");

   a_stage_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_op_ff)))
      else $error("held stage lost its request");
`endif

endmodule
